FILE: hw/rtl/skct_pkg.sv
// Package for the sorted key count table: constants, types and codes.
package skct_pkg;

	localparam int unsigned CAPACITY_DEF   = 1024;
	localparam int unsigned YEAR_SLOTS_DEF = 10;
	localparam logic [11:0] WIN_BASE_RST   = 12'd2009;
	localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;

	// Result status codes
	localparam logic [1:0] ST_UPDATED  = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_YEAR_OOW = 2'd3;

	// Key word: name_high, name_mid, name_low, sex (MSB first)
	localparam int unsigned KEY_W = 64 + 64 + 24 + 8;
	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_UPD_RD,
		S_UPD_WR,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_CLR,
		S_INS,
		S_DONE
	} state_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? SAT32 : s[31:0];
	endfunction

endpackage

FILE: hw/rtl/skct_key_mem.sv
// Record memory: key and total per entry, one write and one registered read port.
module skct_key_mem #(
	parameter int unsigned CAPACITY = 1024,
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  skct_pkg::key_t      wkey,
	input  logic [31:0]         wtotal,
	input  logic [AW-1:0]       raddr,
	output skct_pkg::key_t      rkey,
	output logic [31:0]         rtotal
);
	import skct_pkg::*;

	key_t        key_mem [CAPACITY];
	logic [31:0] tot_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			tot_mem[waddr] <= wtotal;
		end
		rkey   <= key_mem[raddr];
		rtotal <= tot_mem[raddr];
	end

endmodule

FILE: hw/rtl/skct_cnt_mem.sv
// Per-year count memory, one word per entry and year slot.
module skct_cnt_mem #(
	parameter int unsigned DEPTH = 10240,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/sorted_key_count_table_unit.sv
// Top level of the sorted key count table: sequencer, config register, memories.
// Sorted key count table. Each input word is looked up in a table kept in
// ascending key order by binary search over a registered-read record memory
// (up to log2(CAPACITY)+1 probes). A known key has its total and per-year
// count read, saturating-added and written back. An absent key is inserted:
// every later record is moved up one place, one memory word at a time, where
// a record is its key/total word plus YEAR_SLOTS count words; then the new
// record's counts and key are written. If the table is full the word gets
// ST_FULL, and a year outside the window gets ST_YEAR_OOW without a search.
// The shift loop dominates the worst case. One word is worked on at a time;
// the result sits in an output register and in_stall is high while a word is
// in work or the result waits. There is no clearing pass: entries at or above
// entry_total are never read. The window base year is to be written through
// cfg_we/cfg_data only while idle; the block itself does not enforce this.
module sorted_key_count_table_unit #(
	parameter int unsigned CAPACITY   = skct_pkg::CAPACITY_DEF,
	parameter int unsigned YEAR_SLOTS = skct_pkg::YEAR_SLOTS_DEF,
	localparam int unsigned AW  = $clog2(CAPACITY),
	localparam int unsigned CW  = $clog2(CAPACITY + 1),
	localparam int unsigned YW  = (YEAR_SLOTS > 1) ? $clog2(YEAR_SLOTS) : 1,
	localparam int unsigned CAW = $clog2(CAPACITY * YEAR_SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [11:0]   cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [63:0]   name_high,
	input  logic [63:0]   name_mid,
	input  logic [23:0]   name_low,
	input  logic [7:0]    sex_code,
	input  logic [11:0]   year,
	input  logic [19:0]   amount,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic [AW-1:0] position,
	output logic [31:0]   key_total,
	output logic [CW-1:0] entry_total
);
	import skct_pkg::*;

	state_t state_q, state_d;

	logic [11:0]   win_base_q;
	logic [CW-1:0] count_q;
	// search bounds are CW wide so hi can hold entry_count itself
	logic [CW-1:0] lo_q, hi_q, mid_q;
	logic [CW-1:0] shift_q;     // destination record during shift
	logic [YW-1:0] sub_q;       // year slot being written for the new record
	logic [YW:0]   wsel_q;      // word select for shift: YEAR_SLOTS = key word
	key_t          key_q;
	logic [YW-1:0] slot_q;
	logic [19:0]   amt_q;

	// output register
	logic          ov_q;
	logic [1:0]    st_q;
	logic [AW-1:0] pos_q;
	logic [31:0]   tot_q;

	// memory ports
	logic          km_we;
	logic [AW-1:0] km_waddr, km_raddr;
	key_t          km_wkey, km_rkey;
	logic [31:0]   km_wtot, km_rtot;
	logic          cm_we;
	logic [CAW-1:0] cm_waddr, cm_raddr;
	logic [31:0]   cm_wdata, cm_rdata;

	skct_key_mem #(.CAPACITY(CAPACITY)) u_key_mem (
		.clk(clk), .we(km_we), .waddr(km_waddr), .wkey(km_wkey), .wtotal(km_wtot),
		.raddr(km_raddr), .rkey(km_rkey), .rtotal(km_rtot)
	);

	skct_cnt_mem #(.DEPTH(CAPACITY * YEAR_SLOTS)) u_cnt_mem (
		.clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
		.raddr(cm_raddr), .rdata(cm_rdata)
	);

	// count address = record * YEAR_SLOTS + slot
	function automatic logic [CAW-1:0] caddr(input logic [CW-1:0] rec, input logic [YW:0] s);
		logic [CAW+CW:0] p;
		p = (CAW + CW + 1)'(rec) * (CAW + CW + 1)'(YEAR_SLOTS) + (CAW + CW + 1)'(s);
		return p[CAW-1:0];
	endfunction

	// year window check on the incoming word
	logic [12:0] yoff;
	logic        year_ok;
	assign yoff    = {1'b0, year} - {1'b0, win_base_q};
	assign year_ok = !yoff[12] && (yoff[11:0] < 12'(YEAR_SLOTS));

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = ov_q && !out_stall;
	assign in_stall = (state_q != S_IDLE) || ov_q;

	logic [CW-1:0] mid_c;
	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

	logic key_eq, key_gt;
	assign key_eq = key_q == km_rkey;
	assign key_gt = key_q > km_rkey;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		km_we    = 1'b0;
		km_waddr = mid_q[AW-1:0];
		km_wkey  = km_rkey;
		km_wtot  = km_rtot;
		km_raddr = mid_q[AW-1:0];
		cm_we    = 1'b0;
		cm_waddr = caddr(mid_q, {1'b0, slot_q});
		cm_wdata = cm_rdata;
		cm_raddr = caddr(mid_q, {1'b0, slot_q});
		case (state_q)
			S_IDLE: begin
				if (in_acc && year_ok) begin
					state_d = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (lo_q < hi_q) begin
					km_raddr = mid_c[AW-1:0];
					state_d  = S_SRCH_CMP;
				end else if (count_q == CW'(CAPACITY)) begin
					state_d = S_DONE;
				end else if (count_q == lo_q) begin
					state_d = S_CLR;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_SRCH_CMP: begin
				if (key_eq) begin
					state_d = S_UPD_RD;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_UPD_RD: begin
				km_raddr = mid_q[AW-1:0];
				cm_raddr = caddr(mid_q, {1'b0, slot_q});
				state_d  = S_UPD_WR;
			end
			S_UPD_WR: begin
				km_we    = 1'b1;
				km_waddr = mid_q[AW-1:0];
				km_wkey  = km_rkey;
				km_wtot  = sat_add(km_rtot, 32'(amt_q));
				cm_we    = 1'b1;
				cm_waddr = caddr(mid_q, {1'b0, slot_q});
				cm_wdata = sat_add(cm_rdata, 32'(amt_q));
				state_d  = S_DONE;
			end
			S_SHIFT_RD: begin
				// read word wsel of record shift-1
				km_raddr = AW'(shift_q - 1'b1);
				cm_raddr = caddr(shift_q - 1'b1, wsel_q);
				state_d  = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				if (wsel_q == (YW + 1)'(YEAR_SLOTS)) begin
					km_we    = 1'b1;
					km_waddr = shift_q[AW-1:0];
					km_wkey  = km_rkey;
					km_wtot  = km_rtot;
				end else begin
					cm_we    = 1'b1;
					cm_waddr = caddr(shift_q, wsel_q);
					cm_wdata = cm_rdata;
				end
				if (wsel_q == (YW + 1)'(YEAR_SLOTS) && (shift_q - 1'b1) == lo_q) begin
					state_d = S_CLR;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_CLR: begin
				cm_we    = 1'b1;
				cm_waddr = caddr(lo_q, {1'b0, sub_q});
				cm_wdata = (sub_q == slot_q) ? 32'(amt_q) : 32'd0;
				if (sub_q == YW'(YEAR_SLOTS - 1)) begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				km_we    = 1'b1;
				km_waddr = lo_q[AW-1:0];
				km_wkey  = key_q;
				km_wtot  = 32'(amt_q);
				state_d  = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_base_q <= WIN_BASE_RST;
			count_q    <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_base_q <= cfg_data;
			end
			if (out_acc) begin
				ov_q <= 1'b0;
			end
			if (in_acc && !year_ok) begin
				ov_q <= 1'b1;
			end
			if (state_q == S_DONE) begin
				ov_q <= 1'b1;
			end
			if (state_q == S_INS) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					key_q  <= {name_high, name_mid, name_low, sex_code};
					slot_q <= yoff[YW-1:0];
					amt_q  <= amount;
					lo_q   <= '0;
					hi_q   <= count_q;
					sub_q  <= '0;
					st_q   <= ST_YEAR_OOW;
					pos_q  <= '0;
					tot_q  <= '0;
				end
			end
			S_SRCH_RD: begin
				if (lo_q < hi_q) begin
					mid_q <= mid_c;
				end else if (count_q == CW'(CAPACITY)) begin
					st_q  <= ST_FULL;
					pos_q <= '0;
					tot_q <= '0;
				end else begin
					shift_q <= count_q;
					wsel_q  <= (YW + 1)'(0);
				end
			end
			S_SRCH_CMP: begin
				if (!key_eq) begin
					if (key_gt) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
				end
			end
			S_UPD_WR: begin
				st_q  <= ST_UPDATED;
				pos_q <= mid_q[AW-1:0];
				tot_q <= sat_add(km_rtot, 32'(amt_q));
			end
			S_SHIFT_WR: begin
				if (wsel_q == (YW + 1)'(YEAR_SLOTS)) begin
					wsel_q  <= '0;
					shift_q <= shift_q - 1'b1;
				end else begin
					wsel_q <= wsel_q + 1'b1;
				end
			end
			S_CLR: begin
				sub_q <= sub_q + 1'b1;
			end
			S_INS: begin
				st_q  <= ST_INSERTED;
				pos_q <= lo_q[AW-1:0];
				tot_q <= 32'(amt_q);
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = ov_q;
	assign status      = st_q;
	assign position    = pos_q;
	assign key_total   = tot_q;
	assign entry_total = count_q;

endmodule
